/* rtl/tva_pkg.sv */
// tva_pkg: shared constants, status and register codes, and the sideband
// type that travels with each triangle down the pipeline
// no dependencies
`default_nettype none

package tva_pkg;

  // default field widths
  localparam int COORD_BITS_DEF = 12;
  localparam int ID_BITS_DEF    = 16;

  // fixed widths of registers and result fields
  localparam int NODE_W      = 16;
  localparam int LIMIT_W     = 26;
  localparam int AREA_W      = 26;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 26;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_TOTAL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_LIMIT = 1'd1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP_ID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DEGEN  = 2'd3;

  // per-triangle flags carried beside the arithmetic
  typedef struct packed {
    logic id_bad;
    logic id_dup;
    logic cw;
    logic deg;
  } tag_t;

endpackage

`default_nettype wire

/* rtl/tva_cross.sv */
// tva_cross: id checks, edge vectors, partial products and cross product
// three register stages; depends on tva_pkg
`default_nettype none

module tva_cross #(
  parameter int COORD_BITS = tva_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = tva_pkg::ID_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  input  wire        [ID_BITS-1:0]         id_first,
  input  wire        [ID_BITS-1:0]         id_second,
  input  wire        [ID_BITS-1:0]         id_third,
  input  wire signed [COORD_BITS-1:0]      first_x,
  input  wire signed [COORD_BITS-1:0]      first_y,
  input  wire signed [COORD_BITS-1:0]      first_z,
  input  wire signed [COORD_BITS-1:0]      second_x,
  input  wire signed [COORD_BITS-1:0]      second_y,
  input  wire signed [COORD_BITS-1:0]      second_z,
  input  wire signed [COORD_BITS-1:0]      third_x,
  input  wire signed [COORD_BITS-1:0]      third_y,
  input  wire signed [COORD_BITS-1:0]      third_z,
  input  wire        [tva_pkg::NODE_W-1:0] node_total,
  output logic                             out_valid,
  output logic signed [2*COORD_BITS+1:0]   cx,
  output logic signed [2*COORD_BITS+1:0]   cy,
  output logic signed [2*COORD_BITS+1:0]   cz,
  output tva_pkg::tag_t                    out_tag
);

  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int CMP_W = (ID_BITS > tva_pkg::NODE_W) ? ID_BITS : tva_pkg::NODE_W;

  logic [CMP_W-1:0] id0_ext, id1_ext, id2_ext, total_ext;
  logic             id_bad, id_dup;

  logic                 v1;
  logic signed [DW-1:0] abx, aby, abz, acx, acy, acz;
  tva_pkg::tag_t        tag1;

  logic                 v2;
  logic signed [PW-1:0] p_by_cz, p_bz_cy, p_bz_cx, p_bx_cz, p_bx_cy, p_by_cx;
  tva_pkg::tag_t        tag2;

  // id range and duplicate checks on the request
  always_comb begin
    id0_ext   = CMP_W'(id_first);
    id1_ext   = CMP_W'(id_second);
    id2_ext   = CMP_W'(id_third);
    total_ext = CMP_W'(node_total);
    id_bad    = (id0_ext >= total_ext) || (id1_ext >= total_ext) || (id2_ext >= total_ext);
    id_dup    = (id_first == id_second) || (id_second == id_third) || (id_third == id_first);
  end

  // stage 1: edge vectors from the first corner
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    abx         <= DW'(second_x) - DW'(first_x);
    aby         <= DW'(second_y) - DW'(first_y);
    abz         <= DW'(second_z) - DW'(first_z);
    acx         <= DW'(third_x) - DW'(first_x);
    acy         <= DW'(third_y) - DW'(first_y);
    acz         <= DW'(third_z) - DW'(first_z);
    tag1.id_bad <= id_bad;
    tag1.id_dup <= id_dup;
    tag1.cw     <= 1'b0;
    tag1.deg    <= 1'b0;
  end

  // stage 2: six partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    p_by_cz <= PW'(aby) * PW'(acz);
    p_bz_cy <= PW'(abz) * PW'(acy);
    p_bz_cx <= PW'(abz) * PW'(acx);
    p_bx_cz <= PW'(abx) * PW'(acz);
    p_bx_cy <= PW'(abx) * PW'(acy);
    p_by_cx <= PW'(aby) * PW'(acx);
    tag2    <= tag1;
  end

  // stage 3: cross product components
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    cx      <= p_by_cz - p_bz_cy;
    cy      <= p_bz_cx - p_bx_cz;
    cz      <= p_bx_cy - p_by_cx;
    out_tag <= tag2;
  end

endmodule

`default_nettype wire

/* rtl/tva_square.sv */
// tva_square: magnitudes, squares and sum of the cross product components
// three register stages; depends on tva_pkg
`default_nettype none

module tva_square #(
  parameter int COORD_BITS = tva_pkg::COORD_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  input  wire signed [2*COORD_BITS+1:0]   cx,
  input  wire signed [2*COORD_BITS+1:0]   cy,
  input  wire signed [2*COORD_BITS+1:0]   cz,
  input  tva_pkg::tag_t                   in_tag,
  output logic                            out_valid,
  output logic [4*COORD_BITS+3:0]         sum_sq,
  output tva_pkg::tag_t                   out_tag
);

  localparam int XW  = 2 * COORD_BITS + 2;
  localparam int MW  = XW - 1;
  localparam int SQW = 2 * MW;
  localparam int SW  = 2 * XW;

  logic signed [XW-1:0] abs_x, abs_y, abs_z;

  logic          v4;
  logic [MW-1:0] mx, my, mz;
  tva_pkg::tag_t tag4;

  logic           v5;
  logic [SQW-1:0] sqx, sqy, sqz;
  tva_pkg::tag_t  tag5;

  // absolute values; magnitudes always fit one bit below the signed width
  always_comb begin
    abs_x = cx[XW-1] ? -cx : cx;
    abs_y = cy[XW-1] ? -cy : cy;
    abs_z = cz[XW-1] ? -cz : cz;
  end

  // stage 4: magnitudes and clockwise flag
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= in_valid;
    end
    mx          <= abs_x[MW-1:0];
    my          <= abs_y[MW-1:0];
    mz          <= abs_z[MW-1:0];
    tag4.id_bad <= in_tag.id_bad;
    tag4.id_dup <= in_tag.id_dup;
    tag4.cw     <= cz[XW-1];
    tag4.deg    <= in_tag.deg;
  end

  // stage 5: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    sqx  <= SQW'(mx) * SQW'(mx);
    sqy  <= SQW'(my) * SQW'(my);
    sqz  <= SQW'(mz) * SQW'(mz);
    tag5 <= tag4;
  end

  // stage 6: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v5;
    end
    sum_sq  <= SW'(sqx) + SW'(sqy) + SW'(sqz);
    out_tag <= tag5;
  end

endmodule

`default_nettype wire

/* rtl/tva_sqrt.sv */
// tva_sqrt: pipelined floor square root, one root bit per register stage
// restoring compare and subtract per stage; depends on tva_pkg
`default_nettype none

module tva_sqrt #(
  parameter int RW = 2 * (tva_pkg::COORD_BITS_DEF + 1)
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire  [2*RW-1:0]     radicand,
  input  tva_pkg::tag_t       in_tag,
  output logic                out_valid,
  output logic [RW-1:0]       root,
  output tva_pkg::tag_t       out_tag
);

  localparam int SW = 2 * RW;

  logic              vld_q  [1:RW];
  logic [RW+1:0]     rem_q  [1:RW];
  logic [RW-1:0]     root_q [1:RW];
  logic [SW-1:0]     rad_q  [1:RW];
  tva_pkg::tag_t     tag_q  [1:RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic          vld_in;
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] rad_in;
    tva_pkg::tag_t tag_in;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    // stage inputs: request for the first stage, previous stage otherwise
    if (s == 0) begin : g_head
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
      assign tag_in  = in_tag;
    end else begin : g_body
      assign vld_in  = vld_q[s];
      assign rem_in  = rem_q[s];
      assign root_in = root_q[s];
      assign rad_in  = rad_q[s];
      assign tag_in  = tag_q[s];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_in[RW-1:0], rad_in[SW-1:SW-2]};
      trial  = {root_in, 2'b01};
      diff   = {1'b0, rem_sh} - {1'b0, trial};
      ge     = ~diff[RW+2];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_in;
      end
      rem_q[s+1]  <= ge ? diff[RW+1:0] : rem_sh;
      root_q[s+1] <= {root_in[RW-2:0], ge};
      rad_q[s+1]  <= {rad_in[SW-3:0], 2'b00};
      tag_q[s+1]  <= tag_in;
    end
  end

  assign out_valid = vld_q[RW];
  assign root      = root_q[RW];
  assign out_tag   = tag_q[RW];

endmodule

`default_nettype wire

/* rtl/triangle_validity_area_check.sv */
// triangle_validity_area_check: top level, configuration registers,
// pipeline assembly and result register; depends on tva_pkg, tva_cross,
// tva_square and tva_sqrt
//
// Usage: drive a triangle (three node ids, three corners) with start high;
// the request is taken at a rising edge where start is high and busy is low.
// busy is high only in reset and the cycle after, so one triangle can be
// taken in every cycle. Each triangle gives one result: done is high for
// exactly one cycle with status, twice_area and clockwise_xy valid.
// From the accepting edge a triangle passes six stages of cross product
// and sum of squares, one stage per root bit in the square root and one
// result register. Results leave in request order.
// Configuration: cfg_valid/cfg_ready write cfg_data into the register
// cfg_index names (node_total, twice_area_limit); write only while no
// triangle is in flight. The squared limit is registered from the limit
// register and follows it in the next cycle. Reset clears all valid bits
// and both registers. The receiver cannot stall, so the pipeline never
// holds.
`default_nettype none

module triangle_validity_area_check #(
  parameter int COORD_BITS = tva_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = tva_pkg::ID_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // triangle requests
  input  wire                                   start,
  output logic                                  busy,
  input  wire        [ID_BITS-1:0]              id_first,
  input  wire        [ID_BITS-1:0]              id_second,
  input  wire        [ID_BITS-1:0]              id_third,
  input  wire signed [COORD_BITS-1:0]           first_x,
  input  wire signed [COORD_BITS-1:0]           first_y,
  input  wire signed [COORD_BITS-1:0]           first_z,
  input  wire signed [COORD_BITS-1:0]           second_x,
  input  wire signed [COORD_BITS-1:0]           second_y,
  input  wire signed [COORD_BITS-1:0]           second_z,
  input  wire signed [COORD_BITS-1:0]           third_x,
  input  wire signed [COORD_BITS-1:0]           third_y,
  input  wire signed [COORD_BITS-1:0]           third_z,
  // results
  output logic                                  done,
  output logic [tva_pkg::STATUS_W-1:0]          status,
  output logic [tva_pkg::AREA_W-1:0]            twice_area,
  output logic                                  clockwise_xy,
  // configuration writes
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [tva_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [tva_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int XW     = 2 * (COORD_BITS + 1);
  localparam int RW     = XW;
  localparam int SW     = 2 * RW;
  localparam int LSQ_W  = 2 * tva_pkg::LIMIT_W;
  localparam int CMP_W  = (SW > LSQ_W) ? SW : LSQ_W;

  logic [tva_pkg::NODE_W-1:0]  node_total;
  logic [tva_pkg::LIMIT_W-1:0] twice_area_limit;
  logic [LSQ_W-1:0]            limit_sq;

  logic                  accept;
  logic                  cross_valid;
  logic signed [XW-1:0]  cx, cy, cz;
  tva_pkg::tag_t         cross_tag;
  logic                  sum_valid;
  logic [SW-1:0]         sum_sq;
  tva_pkg::tag_t         sum_tag;
  tva_pkg::tag_t         sqrt_in_tag;
  logic                  root_valid;
  logic [RW-1:0]         root;
  tva_pkg::tag_t         root_tag;
  logic [tva_pkg::AREA_W-1:0] area_sat;

  // request handshake
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_total       <= '0;
      twice_area_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tva_pkg::REG_NODE_TOTAL: node_total       <= cfg_data[tva_pkg::NODE_W-1:0];
        tva_pkg::REG_AREA_LIMIT: twice_area_limit <= cfg_data[tva_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // squared limit for the exact degenerate compare
  always_ff @(posedge clk) begin
    limit_sq <= LSQ_W'(twice_area_limit) * LSQ_W'(twice_area_limit);
  end

  // edge vectors and cross product
  tva_cross #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_cross (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .id_first   (id_first),
    .id_second  (id_second),
    .id_third   (id_third),
    .first_x    (first_x),
    .first_y    (first_y),
    .first_z    (first_z),
    .second_x   (second_x),
    .second_y   (second_y),
    .second_z   (second_z),
    .third_x    (third_x),
    .third_y    (third_y),
    .third_z    (third_z),
    .node_total (node_total),
    .out_valid  (cross_valid),
    .cx         (cx),
    .cy         (cy),
    .cz         (cz),
    .out_tag    (cross_tag)
  );

  // squared cross magnitude
  tva_square #(
    .COORD_BITS (COORD_BITS)
  ) u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .cx        (cx),
    .cy        (cy),
    .cz        (cz),
    .in_tag    (cross_tag),
    .out_valid (sum_valid),
    .sum_sq    (sum_sq),
    .out_tag   (sum_tag)
  );

  // degenerate flag joins the sideband as the sum enters the root pipeline
  always_comb begin
    sqrt_in_tag     = sum_tag;
    sqrt_in_tag.deg = CMP_W'(sum_sq) <= CMP_W'(limit_sq);
  end

  tva_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .radicand  (sum_sq),
    .in_tag    (sqrt_in_tag),
    .out_valid (root_valid),
    .root      (root),
    .out_tag   (root_tag)
  );

  // saturate the root to the area field
  if (RW > tva_pkg::AREA_W) begin : g_sat
    assign area_sat = (|root[RW-1:tva_pkg::AREA_W]) ? '1 : root[tva_pkg::AREA_W-1:0];
  end else begin : g_ext
    assign area_sat = tva_pkg::AREA_W'(root);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= root_valid;
    end
    clockwise_xy <= root_tag.cw;
    if (root_tag.id_bad) begin
      status     <= tva_pkg::ST_BAD_ID;
      twice_area <= '0;
    end else if (root_tag.id_dup) begin
      status     <= tva_pkg::ST_DUP_ID;
      twice_area <= '0;
    end else begin
      status     <= root_tag.deg ? tva_pkg::ST_DEGEN : tva_pkg::ST_OK;
      twice_area <= area_sat;
    end
  end

`ifndef ASSERT_OFF
  // a degenerate triangle never reports an area above the limit
  a_degen_bound: assert property (@(posedge clk) disable iff (rst)
    done && (status == tva_pkg::ST_DEGEN) |-> (twice_area <= twice_area_limit))
    else $error("degenerate result with area above limit");

  // a passing triangle never reports an area below the limit
  a_ok_bound: assert property (@(posedge clk) disable iff (rst)
    done && (status == tva_pkg::ST_OK) |-> (twice_area >= twice_area_limit))
    else $error("passing result with area below limit");

  // id failures report zero area
  a_id_fail_area: assert property (@(posedge clk) disable iff (rst)
    done && ((status == tva_pkg::ST_BAD_ID) || (status == tva_pkg::ST_DUP_ID))
    |-> (twice_area == '0))
    else $error("id failure with nonzero area");
`endif

endmodule

`default_nettype wire
